// ===== sv/feedback_rate_adapter_top_macros.svh =====
// Assertion macros for the feedback rate adapter.
// Used by feedback_rate_adapter_top; no other dependencies.
`ifndef FEEDBACK_RATE_ADAPTER_TOP_MACROS_SVH
`define FEEDBACK_RATE_ADAPTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FRA_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("feedback rate adapter check failed");
`define FRA_ASSERT_NXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("feedback rate adapter check failed");
`else
`define FRA_ASSERT_IMP(label, clk, rst, cond, expr)
`define FRA_ASSERT_NXT(label, clk, rst, cond, expr)
`endif
`endif

// ===== sv/fra_pkg.sv =====
// Shared types, constants and the exponential table for the feedback rate adapter.
// No dependencies.
`default_nettype none
package fra_pkg;

   localparam int NODES       = 128;
   localparam int NODE_BITS   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int EXP_ENTRIES = 1024;
   localparam int EXP_BITS    = $clog2(EXP_ENTRIES);
   localparam int FRAC_BITS   = 16;
   localparam int FACTOR_W    = FRAC_BITS + 1;
   localparam int NUM_W       = 43;
   localparam int DEN_W       = 33;

   localparam logic [FACTOR_W-1:0] FACTOR_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [47:0]         ECF_ONE    = 48'(1) << FRAC_BITS;
   localparam logic [63:0]         EXP_STEP   = 64'd4252231657;
   localparam logic [24:0]         ONE_SECOND = 25'h100_0000;
   localparam logic [31:0]         MAX_RATE_RST     = 32'd448000;
   localparam logic [15:0]         PACKET_SIZE_RST  = 16'd210;
   localparam logic [30:0]         PACKET_LIMIT_RST = 31'd268435456;

   typedef enum logic [1:0] {
      CSR_MAX_RATE     = 2'd0,
      CSR_PACKET_SIZE  = 2'd1,
      CSR_PACKET_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      REQ_START    = 2'd0,
      REQ_FEEDBACK = 2'd1,
      REQ_TFRC     = 2'd2,
      REQ_NEXT     = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FB_RD, S_FB_CALC, S_FB_MUL1, S_FB_MUL2, S_MIN_START, S_MIN_RUN,
      S_TF_RD, S_TF_MUL, S_TF_RES, S_DIV_START, S_DIV_RUN, S_DONE
   } state_type;

   typedef struct packed {
      logic                 clear;
      logic                 wr_en;
      logic [NODE_BITS-1:0] addr;
      logic [FACTOR_W-1:0]  factor;
      logic [31:0]          rate;
   } node_cmd_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] factor;
      logic [31:0]         rate;
   } node_rd_type;

   typedef logic [32:0] exp_rom_type [EXP_ENTRIES];

   // E[0] is 1.0 in Q1.32; each entry is the previous one times exp(-1/100), rounded.
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type t;
      logic [63:0] e;
      e    = 64'h1_0000_0000;
      t[0] = 33'(e);
      for (int k = 1; k < EXP_ENTRIES; k++) begin
         e    = (e * EXP_STEP + 64'h8000_0000) >> 32;
         t[k] = 33'(e);
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== sv/fra_node_mem.sv =====
// Per-node factor and rate memories with valid bits that a start clears at once.
// Depends on fra_pkg.
`default_nettype none
module fra_node_mem (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fra_pkg::node_cmd_type cmd,
   input  wire logic [31:0]          restart_rate,
   output fra_pkg::node_rd_type      rd
);
   import fra_pkg::*;

   logic [FACTOR_W-1:0] factor_mem [NODES];
   logic [31:0]         rate_mem [NODES];
   logic [NODES-1:0]    valid_ff;
   logic [FACTOR_W-1:0] factor_q_ff;
   logic [31:0]         rate_q_ff;
   logic                vld_q_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         factor_mem[cmd.addr] <= cmd.factor;
         rate_mem[cmd.addr]   <= cmd.rate;
      end
      factor_q_ff <= factor_mem[cmd.addr];
      rate_q_ff   <= rate_mem[cmd.addr];
      vld_q_ff    <= valid_ff[cmd.addr];
   end

   // An entry not written since the last start reads as the start values.
   assign rd.factor = vld_q_ff ? factor_q_ff : FACTOR_ONE;
   assign rd.rate   = vld_q_ff ? rate_q_ff : restart_rate;

endmodule
`default_nettype wire

// ===== sv/fra_div.sv =====
// Restoring divider, one quotient bit per cycle, for the interval computation.
// Depends on fra_pkg.
`default_nettype none
module fra_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [fra_pkg::NUM_W-1:0] num,
   input  wire logic [fra_pkg::DEN_W-1:0] den,
   output logic                           done,
   output logic [fra_pkg::NUM_W-1:0]      quo
);
   import fra_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W:0]   rem_ff, rem_in, rem_sh;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_sh  = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

// ===== sv/feedback_rate_adapter_top.sv =====
// Top level of the feedback rate adapter: sequencer, shared multiplier, exp ROM.
// Depends on fra_pkg, fra_node_mem, fra_div and the assertion macro header.
//
// Channel  Direction  Handshake                    Payload
// req      in         req_valid / req_ready        type, ecf_value, source_node, tfrc, backlog
// rsp      out        rsp_valid / rsp_ready        interval_q, last_packet, current_rate, bytes
// csr      in         csr_write_en (no wait)       csr_index, csr_write_data
//
// One item at a time. Feedback items walk over all 128 node rates, one memory read
// per cycle, and then run the interval divider; start and next-packet items go
// straight to the divider, TFRC items after the multiply. A finished item waits in the output
// register while the next one is accepted. Reset is synchronous; node entries read as
// start values through valid bits, so no clearing pass is needed.
`default_nettype none
`include "feedback_rate_adapter_top_macros.svh"
module feedback_rate_adapter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [47:0] req_ecf_value,
   input  wire logic [6:0]  req_source_node,
   input  wire logic [28:0] req_tfrc_rate,
   input  wire logic [15:0] req_backlog,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [24:0]      rsp_interval_q,
   output logic             rsp_last_packet,
   output logic [31:0]      rsp_current_rate,
   output logic [15:0]      rsp_sent_bytes,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   import fra_pkg::*;

   localparam exp_rom_type EXP_ROM = build_exp_rom();
   localparam int CNT_W = NODE_BITS + 1;

   state_type state_ff, state_in;

   logic [31:0] max_rate_ff, restart_rate_ff, rate_now_ff, count_ff, min_ff, min_next;
   logic [15:0] size_ff;
   logic [30:0] limit_ff;
   logic [47:0] ecf_ff, ecf_int;
   logic [10:0] src_ff;
   logic [28:0] tfrc_ff;
   logic [15:0] backlog_ff;
   logic [FACTOR_W-1:0] factor_new_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [64:0] mul_prod_ff;
   logic [32:0] exp_q_ff, tf_rate;
   logic        last_ff, exp_zero, src_ok, accept, rsp_load;
   logic [31:0] count_inc;

   logic        rsp_valid_ff;
   logic [24:0] rsp_interval_ff;
   logic        rsp_last_ff;
   logic [31:0] rsp_rate_ff;
   logic [15:0] rsp_bytes_ff;

   node_cmd_type node_cmd;
   node_rd_type  node_rd;
   logic [31:0]  mul_a;
   logic [32:0]  mul_b;
   logic         div_start, div_done;
   logic [NUM_W-1:0] div_quo;

   fra_node_mem u_node_mem (
      .clock        (clock),
      .reset        (reset),
      .cmd          (node_cmd),
      .restart_rate (restart_rate_ff),
      .rd           (node_rd)
   );

   fra_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({size_ff, 27'b0}),
      .den   ({1'b0, rate_now_ff} + DEN_W'(1)),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign accept   = req_valid && req_ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign src_ok   = src_ff < 11'(NODES);
   assign exp_zero = backlog_ff >= 16'(EXP_ENTRIES);
   assign ecf_int  = ecf_ff >> FRAC_BITS;
   assign tf_rate  = mul_prod_ff[64:32];
   assign count_inc = (count_ff == 32'hFFFF_FFFF) ? count_ff : count_ff + 32'd1;
   assign min_next = ((cnt_ff != '0) && (node_rd.rate < min_ff)) ? node_rd.rate : min_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_kind_type'(req_type))
                  REQ_START:    state_in = S_DIV_START;
                  REQ_FEEDBACK: state_in = S_FB_RD;
                  REQ_TFRC:     state_in = S_TF_RD;
                  default:      state_in = S_DIV_START;
               endcase
            end
         end
         S_FB_RD:     state_in = src_ok ? S_FB_CALC : S_MIN_START;
         S_FB_CALC:   state_in = (ecf_ff < ECF_ONE) ? S_FB_MUL1 : S_MIN_START;
         S_FB_MUL1:   state_in = S_FB_MUL2;
         S_FB_MUL2:   state_in = S_MIN_START;
         S_MIN_START: state_in = S_MIN_RUN;
         S_MIN_RUN:   state_in = (cnt_ff == CNT_W'(NODES)) ? S_DIV_START : S_MIN_RUN;
         S_TF_RD:     state_in = S_TF_MUL;
         S_TF_MUL:    state_in = S_TF_RES;
         S_TF_RES:    state_in = S_DIV_START;
         S_DIV_START: state_in = S_DIV_RUN;
         S_DIV_RUN:   state_in = div_done ? S_DONE : S_DIV_RUN;
         S_DONE:      state_in = rsp_load ? S_IDLE : S_DONE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, node memory command, multiplier operands.
   always_comb begin
      req_ready       = (state_ff == S_IDLE);
      node_cmd.clear  = accept && (req_kind_type'(req_type) == REQ_START);
      node_cmd.wr_en  = 1'b0;
      node_cmd.addr   = src_ff[NODE_BITS-1:0];
      node_cmd.factor = node_rd.factor;
      node_cmd.rate   = max_rate_ff;
      mul_a           = 32'(node_rd.factor);
      mul_b           = 33'(ecf_ff[FRAC_BITS-1:0]);
      div_start       = (state_ff == S_DIV_START);
      case (state_ff)
         S_FB_CALC: begin
            if (ecf_ff > ECF_ONE) begin
               node_cmd.wr_en = 1'b1;
               node_cmd.rate  = (ecf_int > 48'(max_rate_ff)) ? max_rate_ff : ecf_int[31:0];
            end
         end
         S_FB_MUL1: begin
            mul_a = max_rate_ff;
            mul_b = 33'(mul_prod_ff[FRAC_BITS +: FACTOR_W]);
         end
         S_FB_MUL2: begin
            node_cmd.wr_en  = 1'b1;
            node_cmd.factor = factor_new_ff;
            node_cmd.rate   = mul_prod_ff[FRAC_BITS +: 32];
         end
         S_MIN_RUN: begin
            node_cmd.addr = cnt_ff[NODE_BITS-1:0];
         end
         S_TF_MUL: begin
            mul_a = {tfrc_ff, 3'b000};
            mul_b = exp_zero ? 33'd0 : exp_q_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         max_rate_ff     <= MAX_RATE_RST;
         size_ff         <= PACKET_SIZE_RST;
         limit_ff        <= PACKET_LIMIT_RST;
         restart_rate_ff <= MAX_RATE_RST;
         rate_now_ff     <= MAX_RATE_RST;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_RATE:     max_rate_ff <= csr_write_data;
               CSR_PACKET_SIZE:  size_ff     <= csr_write_data[15:0];
               CSR_PACKET_LIMIT: limit_ff    <= csr_write_data[30:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            case (req_kind_type'(req_type))
               REQ_START: begin
                  restart_rate_ff <= max_rate_ff;
                  rate_now_ff     <= max_rate_ff;
               end
               REQ_NEXT: count_ff <= count_inc;
               default: begin
               end
            endcase
         end
         if ((state_ff == S_MIN_RUN) && (cnt_ff == CNT_W'(NODES))) begin
            rate_now_ff <= min_next;
         end
         if (state_ff == S_TF_RES) begin
            rate_now_ff <= (tf_rate > 33'(max_rate_ff)) ? max_rate_ff : tf_rate[31:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mul_prod_ff <= mul_a * mul_b;
      exp_q_ff    <= EXP_ROM[backlog_ff[EXP_BITS-1:0]];
      if (accept) begin
         ecf_ff     <= req_ecf_value;
         src_ff     <= 11'(req_source_node);
         tfrc_ff    <= req_tfrc_rate;
         backlog_ff <= req_backlog;
         last_ff    <= (req_kind_type'(req_type) == REQ_NEXT) &&
                       (count_inc >= 32'(limit_ff));
      end
      if (state_ff == S_FB_MUL1) begin
         factor_new_ff <= mul_prod_ff[FRAC_BITS +: FACTOR_W];
      end
      if (state_ff == S_MIN_START) begin
         cnt_ff <= '0;
         min_ff <= max_rate_ff;
      end else if (state_ff == S_MIN_RUN) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         min_ff <= min_next;
      end
      if (rsp_load) begin
         rsp_interval_ff <= (div_quo > NUM_W'(ONE_SECOND)) ? ONE_SECOND : div_quo[24:0];
         rsp_last_ff     <= last_ff;
         rsp_rate_ff     <= rate_now_ff;
         rsp_bytes_ff    <= size_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interval_q   = rsp_interval_ff;
   assign rsp_last_packet  = rsp_last_ff;
   assign rsp_current_rate = rsp_rate_ff;
   assign rsp_sent_bytes   = rsp_bytes_ff;

   // The divider finishes only while the sequencer waits for it.
   `FRA_ASSERT_IMP(a_div_done_in_run, clock, reset, div_done, state_ff == S_DIV_RUN)
   // A result never reports more than one second.
   `FRA_ASSERT_IMP(a_interval_clamp, clock, reset, rsp_valid, rsp_interval_q <= ONE_SECOND)
   // A last-packet flag means the counter has reached the limit.
   `FRA_ASSERT_IMP(a_last_count, clock, reset, rsp_valid && rsp_last_packet,
                   count_ff >= 32'(limit_ff))
   // A new item is taken only with the sequencer idle and leaves it busy.
   `FRA_ASSERT_NXT(a_accept_busy, clock, reset, accept, state_ff != S_IDLE)

endmodule
`default_nettype wire
